@@ hw/rtl/ilfe_pkg.sv @@
// Shared types and constants for the IPv4 prefix-match forwarding engine.
`default_nettype none
package ilfe_pkg;
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_WORD  = 2'd2;

  localparam logic [2:0] ST_FORWARD = 3'd0;
  localparam logic [2:0] ST_LOCAL   = 3'd1;
  localparam logic [2:0] ST_TTL     = 3'd2;
  localparam logic [2:0] ST_NOROUTE = 3'd3;
  localparam logic [2:0] ST_ADDED   = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  localparam logic [5:0] MAX_PREFIX = 6'd32;

  // controller -> datapath
  typedef struct packed {
    logic word_take;    // absorb header word
    logic add_take;     // write route
    logic clear_take;   // empty table
    logic scan_start;   // begin table search
    logic scan_step;    // examine one entry
    logic pkt_reset;    // packet state back to start
  } ilfe_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic table_full;
    logic scan_done;
  } ilfe_stat_t;

  function automatic logic [15:0] add_fold(input logic [16:0] sum, input logic [15:0] half);
    logic [17:0] s;
    s = {2'b0, sum[15:0]} + {17'b0, sum[16]} + {2'b0, half};
    return s[15:0] + {15'b0, s[16]} + {15'b0, s[17]};
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/ilfe_ctrl.sv @@
// Control state machine: sequences commands, table search and result transfer.
`default_nettype none
module ilfe_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          command,
  input  wire logic                last_word,
  input  wire logic                early_done,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ilfe_pkg::ilfe_cmd_t      cmd,
  input  wire ilfe_pkg::ilfe_stat_t stat,
  output logic                     load_early,
  output logic                     load_scan
);
  import ilfe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEC  = 4'b0010,
    S_SCAN = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   acc;

  assign acc       = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    load_early = 1'b0;
    load_scan  = 1'b0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (command)
            CMD_CLEAR: cmd.clear_take = 1'b1;
            CMD_ADD: begin
              cmd.add_take = 1'b1;
              load_early   = 1'b1;
              state_next   = S_OUT;
            end
            CMD_WORD: begin
              cmd.word_take = 1'b1;
              if (last_word) state_next = S_DEC;
            end
            default: ;
          endcase
        end
      end
      S_DEC: begin
        cmd.pkt_reset = 1'b1;
        if (early_done) begin
          load_early = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          load_scan  = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

@@ hw/rtl/ilfe_dp.sv @@
// Datapath: route table memory, header accumulation, search and result register.
`default_nettype none
module ilfe_dp #(
  parameter int TABLE_DEPTH      = 64,
  parameter int MAX_HEADER_WORDS = 15
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ilfe_pkg::ilfe_cmd_t  cmd,
  output ilfe_pkg::ilfe_stat_t      stat,
  input  wire logic                 load_early,
  input  wire logic                 load_scan,
  output logic                      early_done,
  input  wire logic [31:0]          local_address,
  input  wire logic [31:0]          route_dest,
  input  wire logic [5:0]           prefix_length,
  input  wire logic [31:0]          route_next_hop,
  input  wire logic [31:0]          header_word,
  output logic [2:0]                status,
  output logic [31:0]               next_hop,
  output logic [15:0]               new_checksum,
  output logic [7:0]                new_ttl
);
  import ilfe_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [69:0]   mem [TABLE_DEPTH];
  logic [CW-1:0] entry_count;
  logic [3:0]    word_position;
  logic [16:0]   running_sum;
  logic [7:0]    saved_ttl;
  logic [31:0]   saved_destination;
  logic [7:0]    pkt_ttl;
  logic [31:0]   pkt_dst;
  logic [15:0]   pkt_sum;

  logic [5:0]    add_len;
  assign add_len = (prefix_length > MAX_PREFIX) ? MAX_PREFIX : prefix_length;
  assign stat.table_full = (entry_count == CW'(TABLE_DEPTH));

  // header accumulation
  logic [15:0] s1, s2, hi;
  logic [7:0]  ttl_m1;
  always_comb begin
    ttl_m1 = header_word[31:24] - 8'd1;
    hi     = {ttl_m1, header_word[23:16]};
    if (word_position == 4'd2) begin
      s1 = add_fold(running_sum, hi);
      s2 = s1;
    end else begin
      s1 = add_fold(running_sum, header_word[31:16]);
      s2 = add_fold({1'b0, s1}, header_word[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count       <= '0;
      word_position     <= '0;
      running_sum       <= '0;
      saved_ttl         <= '0;
      saved_destination <= '0;
    end else begin
      if (cmd.clear_take) entry_count <= '0;
      if (cmd.add_take && !stat.table_full) entry_count <= entry_count + CW'(1);
      if (cmd.pkt_reset) begin
        word_position     <= '0;
        running_sum       <= '0;
        saved_ttl         <= '0;
        saved_destination <= '0;
      end else if (cmd.word_take && (word_position < 4'(MAX_HEADER_WORDS))) begin
        running_sum   <= {1'b0, s2};
        word_position <= word_position + 4'd1;
        if (word_position == 4'd2) saved_ttl <= header_word[31:24];
        if (word_position == 4'd4) saved_destination <= header_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_take && !stat.table_full)
      mem[entry_count[AW-1:0]] <= {route_dest, add_len, route_next_hop};
  end

  // packet snapshot on decision
  always_ff @(posedge clk) begin
    if (cmd.pkt_reset) begin
      pkt_ttl <= saved_ttl;
      pkt_dst <= saved_destination;
      pkt_sum <= add_fold(running_sum, 16'd0);
    end
  end

  assign early_done = (saved_ttl == 8'd0) || (saved_destination == local_address);

  // table search, one entry per cycle (memory read registered)
  logic [CW-1:0] scan_idx;
  logic          rd_valid;
  logic [69:0]   rd_data;
  logic          found;
  logic [5:0]    best_len;
  logic [31:0]   best_hop;
  logic          more;
  assign more = scan_idx < entry_count;

  always_ff @(posedge clk) begin
    rd_data <= mem[scan_idx[AW-1:0]];
  end

  logic [31:0] m;
  logic        hit;
  always_comb begin
    m   = (rd_data[37:32] == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - rd_data[37:32]));
    hit = rd_valid && (!found || rd_data[37:32] > best_len) &&
          ((pkt_dst & m) == (rd_data[69:38] & m));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      scan_idx <= '0;
      found    <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_idx <= '0;
      rd_valid <= 1'b0;
      found    <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_valid <= more;
      if (more) scan_idx <= scan_idx + CW'(1);
      if (hit) begin
        found    <= 1'b1;
        best_len <= rd_data[37:32];
        best_hop <= rd_data[31:0];
      end
    end
  end
  assign stat.scan_done = !more && !rd_valid && !cmd.scan_start;

  // result register
  always_ff @(posedge clk) begin
    if (load_early) begin
      next_hop     <= '0;
      new_checksum <= '0;
      new_ttl      <= '0;
      if (cmd.add_take) status <= stat.table_full ? ST_FULL : ST_ADDED;
      else if (saved_ttl == 8'd0) status <= ST_TTL;
      else status <= ST_LOCAL;
    end else if (load_scan) begin
      if (found) begin
        status       <= ST_FORWARD;
        next_hop     <= best_hop;
        new_checksum <= ~pkt_sum;
        new_ttl      <= pkt_ttl - 8'd1;
      end else begin
        status       <= ST_NOROUTE;
        next_hop     <= '0;
        new_checksum <= '0;
        new_ttl      <= '0;
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/ipv4_lpm_forward_engine_unit.sv @@
// Top level of the IPv4 prefix-match forwarding engine.
// Header words that are not last and clear commands leave the engine idle; an add route
// waits for its result transfer. A last header word with TTL discard or local delivery
// skips the table search; otherwise the search examines one entry per cycle.
// One item at a time. Synchronous active-high reset clears the route count,
// packet state and local_address; table contents stay undefined until written.
`default_nettype none
module ipv4_lpm_forward_engine_unit #(
  parameter int TABLE_DEPTH      = 64,
  parameter int MAX_HEADER_WORDS = 15
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] route_dest,
  input  wire logic [5:0]  prefix_length,
  input  wire logic [31:0] route_next_hop,
  input  wire logic [31:0] header_word,
  input  wire logic        last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [31:0]      next_hop,
  output logic [15:0]      new_checksum,
  output logic [7:0]       new_ttl
);
  import ilfe_pkg::*;

  logic [31:0] local_address;
  ilfe_cmd_t   cmd;
  ilfe_stat_t  stat;
  logic        load_early, load_scan, early_done;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? local_address : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) local_address <= '0;
    else if (psel && penable && pwrite && paddr == 2'd0) local_address <= pwdata;
  end

  ilfe_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .command, .last_word, .early_done,
    .out_valid, .out_ready, .cmd, .stat, .load_early, .load_scan
  );

  ilfe_dp #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_HEADER_WORDS(MAX_HEADER_WORDS)) u_dp (
    .clk, .rst, .cmd, .stat, .load_early, .load_scan, .early_done, .local_address,
    .route_dest, .prefix_length, .route_next_hop, .header_word,
    .status, .next_hop, .new_checksum, .new_ttl
  );
endmodule
`default_nettype wire

@@ hw/rtl/ilfe_checker.sv @@
// Port-level checks for the forwarding engine, bound to the top level.
`default_nettype none
module ilfe_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] command,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] status
);
  import ilfe_pkg::*;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_add_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_ADD |=> out_valid &&
    (status == ST_ADDED || status == ST_FULL)) else $error("add gave no result");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_FULL) else $error("bad status");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)) else $error("result dropped");
endmodule

bind ipv4_lpm_forward_engine_unit ilfe_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .command, .out_valid, .out_ready, .status
);
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the IPv4 prefix-match forwarding engine.
`default_nettype none
module tb;
  import ilfe_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0, in_ready;
  logic [1:0]  command = CMD_CLEAR;
  logic [31:0] route_dest = '0, route_next_hop = '0, header_word = '0;
  logic [5:0]  prefix_length = '0;
  logic        last_word = 1'b0;
  logic        out_valid, out_ready = 1'b0;
  logic [2:0]  status;
  logic [31:0] next_hop;
  logic [15:0] new_checksum;
  logic [7:0]  new_ttl;

  ipv4_lpm_forward_engine_unit dut (.*);

  always #2 clk = ~clk;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] dest;
    logic [5:0]  plen;
    logic [31:0] hop;
    logic [31:0] word;
    logic        last;
  } req_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [31:0] hop;
    logic [15:0] cks;
    logic [7:0]  ttl;
  } verdict_t;

  // predictor state
  logic [31:0] rt_dest[64];
  logic [5:0]  rt_len[64];
  logic [31:0] rt_hop[64];
  int          rt_count;
  int          pkt_pos;
  logic [16:0] pkt_sum;
  logic [7:0]  pkt_ttl;
  logic [31:0] pkt_dst;
  logic [31:0] my_addr;

  verdict_t    pending_verdicts[$];
  int          errors, cycles, verdicts_seen, forwards_seen;
  int          stall_pat;

  function automatic logic [16:0] fold16(logic [16:0] s, logic [15:0] h);
    logic [17:0] t;
    t = {1'b0, s} + {2'b0, h};
    t = {2'b0, t[15:0]} + {16'b0, t[17:16]};
    return {1'b0, t[15:0]} + {16'b0, t[16]};
  endfunction

  function automatic logic [31:0] prefix_mask(logic [5:0] l);
    return (l == 0) ? 32'h0 : (32'hffff_ffff << (32 - l));
  endfunction

  // returns 1 when the item yields a verdict
  function automatic bit forward_decide(req_t r, output verdict_t v);
    logic [5:0]  l, best_len;
    logic [31:0] best_hop, m;
    logic [7:0]  t;
    logic [31:0] d;
    bit          hit;
    v = '0;
    case (r.cmd)
      CMD_CLEAR: begin
        rt_count = 0;
        return 0;
      end
      CMD_ADD: begin
        l = (r.plen > MAX_PREFIX) ? MAX_PREFIX : r.plen;
        if (rt_count >= 64) begin
          v.st = ST_FULL;
          return 1;
        end
        rt_dest[rt_count] = r.dest;
        rt_len[rt_count] = l;
        rt_hop[rt_count] = r.hop;
        rt_count++;
        v.st = ST_ADDED;
        return 1;
      end
      CMD_WORD: begin
        if (pkt_pos < 15) begin
          if (pkt_pos == 2) begin
            pkt_ttl = r.word[31:24];
            pkt_sum = fold16(pkt_sum, {r.word[31:24] - 8'd1, r.word[23:16]});
          end else begin
            if (pkt_pos == 4) pkt_dst = r.word;
            pkt_sum = fold16(pkt_sum, r.word[31:16]);
            pkt_sum = fold16(pkt_sum, r.word[15:0]);
          end
          pkt_pos++;
        end
        if (!r.last) return 0;
        t = pkt_ttl;
        d = pkt_dst;
        m = {16'b0, ~pkt_sum[15:0]};
        pkt_pos = 0; pkt_sum = '0; pkt_ttl = '0; pkt_dst = '0;
        if (t == 0) begin
          v.st = ST_TTL;
          return 1;
        end
        if (d == my_addr) begin
          v.st = ST_LOCAL;
          return 1;
        end
        hit = 0; best_len = 0; best_hop = 0;
        for (int i = 0; i < rt_count; i++)
          if ((!hit || rt_len[i] > best_len) &&
              ((d ^ rt_dest[i]) & prefix_mask(rt_len[i])) == 0) begin
            hit = 1; best_len = rt_len[i]; best_hop = rt_hop[i];
          end
        if (!hit) begin
          v.st = ST_NOROUTE;
          return 1;
        end
        v.st = ST_FORWARD; v.hop = best_hop; v.cks = m[15:0]; v.ttl = t - 8'd1;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // output side: pattern stall, compare each transfer
  always @(posedge clk) begin
    verdict_t w;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected transfer", {29'b0, status}, 32'd0);
      end else begin
        w = pending_verdicts.pop_front();
        if (w.st == ST_FORWARD) forwards_seen++;
        if (status !== w.st) report_mismatch("status", {29'b0, status}, {29'b0, w.st});
        if (next_hop !== w.hop) report_mismatch("next_hop", next_hop, w.hop);
        if (new_checksum !== w.cks)
          report_mismatch("new_checksum", {16'b0, new_checksum}, {16'b0, w.cks});
        if (new_ttl !== w.ttl) report_mismatch("new_ttl", {24'b0, new_ttl}, {24'b0, w.ttl});
      end
    end
  end

  always @(negedge clk) begin
    stall_pat <= stall_pat + 1;
    case (stall_pat[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(3, 0) != 0);
      2'd2: out_ready <= stall_pat[2] | stall_pat[0];
      default: out_ready <= ($urandom_range(1, 0) != 0);
    endcase
  end

  always @(posedge clk)
    if (cycles > 2_000_000) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end

  int burst_left;

  // valid stays up after a transfer until the next item or an idle point replaces it
  task automatic send(req_t r);
    verdict_t v;
    int       gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6, 0);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(12, 1);
    end
    burst_left--;
    in_valid <= 1'b1;
    command <= r.cmd; route_dest <= r.dest; prefix_length <= r.plen;
    route_next_hop <= r.hop; header_word <= r.word; last_word <= r.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (forward_decide(r, v)) pending_verdicts = {pending_verdicts, v};
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic apb_write(logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    my_addr = val;
  endtask

  function automatic req_t mk_add(logic [31:0] d, logic [5:0] l, logic [31:0] h);
    req_t r;
    r = '0; r.cmd = CMD_ADD; r.dest = d; r.plen = l; r.hop = h;
    r.word = $urandom(); r.last = 1'($urandom_range(1, 0));
    return r;
  endfunction

  function automatic req_t mk_word(logic [31:0] w, logic l);
    req_t r;
    r = '0; r.cmd = CMD_WORD; r.word = w; r.last = l;
    r.dest = $urandom(); r.hop = $urandom(); r.plen = 6'($urandom());
    return r;
  endfunction

  // a packet of nwords words, TTL and destination as given
  task automatic send_packet(int nwords, logic [7:0] ttl, logic [31:0] dst);
    logic [31:0] w;
    for (int i = 0; i < nwords; i++) begin
      w = $urandom();
      if (i == 2) w[31:24] = ttl;
      if (i == 4) w = dst;
      send(mk_word(w, i == nwords - 1));
    end
  endtask

  function automatic logic [31:0] pick_dst();
    int k;
    k = $urandom_range(9, 0);
    if (k < 6 && rt_count > 0)
      return rt_dest[$urandom_range(rt_count - 1, 0)] ^ ($urandom() >> $urandom_range(32, 8));
    if (k == 6) return my_addr;
    return $urandom();
  endfunction

  req_t plan[$];

  initial begin
    req_t r;
    logic [31:0] addrs[4];
    rt_count = 0; pkt_pos = 0; pkt_sum = '0; pkt_ttl = '0; pkt_dst = '0; my_addr = '0;
    errors = 0; verdicts_seen = 0; forwards_seen = 0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: route extremes, then packets probing each fate
    plan = {plan, mk_add(32'h0a00_0000, 6'd8, 32'h0101_0101)};
    plan = {plan, mk_add(32'h0a01_0000, 6'd16, 32'h0202_0202)};
    plan = {plan, mk_add(32'h0a01_02ff, 6'd24, 32'h0303_0303)};
    plan = {plan, mk_add(32'h0a01_0000, 6'd16, 32'hdead_beef)};   // tie: earlier wins
    plan = {plan, mk_add(32'hffff_ffff, 6'd63, 32'hffff_ffff)};   // clipped to 32
    plan = {plan, mk_add(32'h0, 6'd0, 32'h0)};
    r = '0; r.cmd = CMD_SPARE; r.word = 32'hffff_ffff; r.last = 1'b1;   // unused code
    plan = {plan, r};
    foreach (plan[i]) send(plan[i]);
    for (int i = 0; i < 15; i++) send(mk_word(32'h4500_0054, 1'b0)); // overlong header
    send(mk_word(32'h0, 1'b1));                // past the limit, only ends the packet
    send_packet(5, 8'hff, 32'h0a01_0203);
    send_packet(5, 8'd1, 32'h0a01_0905);
    send_packet(5, 8'h40, 32'hffff_ffff);
    send_packet(3, 8'h80, 32'h0);              // short: dst zero == local reset value
    send(mk_word(32'hffff_ffff, 1'b1));        // one word: TTL zero
    drain();
    r = '0; r.cmd = CMD_CLEAR; send(r);
    send_packet(5, 8'h10, 32'h0a00_0001);      // empty table
    drain();

    addrs[0] = 32'hffff_ffff; addrs[1] = 32'h0; addrs[2] = 32'hc0a8_0001;
    addrs[3] = $urandom();
    for (int ph = 0; ph < 4; ph++) begin
      apb_write(addrs[ph]);
      r = '0; r.cmd = CMD_CLEAR; send(r);
      if (ph == 1)  // fill past capacity
        for (int i = 0; i < 66; i++)
          send(mk_add($urandom(), 6'($urandom_range(32, 0)), $urandom()));
      for (int n = 0; n < 340 / 4; n++) begin
        case ($urandom_range(9, 0))
          0, 1: send(mk_add($urandom(), 6'($urandom_range(63, 0)), $urandom()));
          2: send(mk_add(pick_dst(), 6'($urandom_range(32, 0)), $urandom()));
          3: begin
            r = mk_word($urandom(), 1'($urandom_range(1, 0)));
            r.cmd = ($urandom_range(3, 0) == 0) ? CMD_SPARE : CMD_WORD;
            send(r);
          end
          4: if ($urandom_range(7, 0) == 0) begin
            r = '0; r.cmd = CMD_CLEAR; send(r);
          end
          default: send_packet(($urandom_range(4, 0) == 0) ? $urandom_range(16, 1) : 5,
                               ($urandom_range(9, 0) == 0) ? 8'd0 : 8'($urandom()),
                               pick_dst());
        endcase
        if (n == 35) drain();
      end
      drain();
    end

    $display("covered %0d outputs (%0d forwarded) over 4 local addresses, table fill and clear",
             verdicts_seen, forwards_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("errors: %0d", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
hw/rtl/ilfe_pkg.sv
hw/rtl/ilfe_ctrl.sv
hw/rtl/ilfe_dp.sv
hw/rtl/ipv4_lpm_forward_engine_unit.sv
hw/rtl/ilfe_checker.sv
bench/tb.sv
